@@ rtl/disc_elastic_collision_top_defines.svh @@
// Assertion macros shared by the RTL files.
`ifndef DISC_ELASTIC_COLLISION_TOP_DEFINES_SVH
`define DISC_ELASTIC_COLLISION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DEC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define DEC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define DEC_ASSERT(lbl, prop, msg)
`define DEC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/dec_pkg.sv @@
`timescale 1ns / 1ps

package dec_pkg;

   localparam int VW   = 24;          // velocity / position width
   localparam int RW   = 23;          // radius width
   localparam int DW   = VW + 1;      // position difference
   localparam int RSW  = RW + 1;      // radius sum
   localparam int RRW  = 2 * RSW;     // radius sum squared
   localparam int DDW  = 2 * DW;      // squared distance
   localparam int PW   = 2 * VW + 1;  // velocity * difference product
   localparam int VDW  = PW + 1;      // dot product
   localparam int QW   = 25;          // projection quotient, |q| <= |v| < 2^25
   localparam int NW   = DDW + QW;    // dividend |vd * dc|
   localparam int HW   = VDW / 2;     // split of the dot product magnitude
   localparam int LANES = 4;

   typedef struct packed {
      logic                  hit;
      logic signed [DW-1:0]  dx;
      logic signed [DW-1:0]  dy;
      logic [DDW-1:0]        dd;
      logic signed [VDW-1:0] vda;
      logic signed [VDW-1:0] vdb;
      logic signed [VW-1:0]  avx;
      logic signed [VW-1:0]  avy;
      logic signed [VW-1:0]  bvx;
      logic signed [VW-1:0]  bvy;
   } dec_task_type;

   localparam int TW = $bits(dec_task_type);

endpackage

@@ rtl/disc_elastic_collision_top.sv @@
`timescale 1ns / 1ps
// Two-disc equal-mass elastic collision response, one disc pair per word.
// Input channel req_*: positions, velocities and radii of discs A and B
// (signed Q12.12, radii unsigned). Result channel rsp_*: hit flag and the
// four new velocities, saturated to 24 bits; without a hit they equal the
// input velocities.
// Throughput: one word per cycle while rsp_ready stays high. The path from
// req accept to rsp_valid runs through 4 classify stages, the queue, 3 setup
// stages, 25 divider stages at one quotient bit each and 1 output register.
// The divider pipeline length sets the latency.
// The classify part and the divide part run from a small queue between
// them; a stall on rsp_ready freezes the divide pipeline, the queue fills,
// then the classify pipeline freezes and req_ready drops.
// Reset (synchronous, active high) empties every stage and the queue; the
// block accepts a word in the first cycle after reset.
module disc_elastic_collision_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [dec_pkg::VW-1:0] req_a_pos_x,
   input  logic signed [dec_pkg::VW-1:0] req_a_pos_y,
   input  logic signed [dec_pkg::VW-1:0] req_a_vel_x,
   input  logic signed [dec_pkg::VW-1:0] req_a_vel_y,
   input  logic [dec_pkg::RW-1:0]        req_a_rad,
   input  logic signed [dec_pkg::VW-1:0] req_b_pos_x,
   input  logic signed [dec_pkg::VW-1:0] req_b_pos_y,
   input  logic signed [dec_pkg::VW-1:0] req_b_vel_x,
   input  logic signed [dec_pkg::VW-1:0] req_b_vel_y,
   input  logic [dec_pkg::RW-1:0]        req_b_rad,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [dec_pkg::VW-1:0] rsp_a_new_vx,
   output logic signed [dec_pkg::VW-1:0] rsp_a_new_vy,
   output logic signed [dec_pkg::VW-1:0] rsp_b_new_vx,
   output logic signed [dec_pkg::VW-1:0] rsp_b_new_vy
);
   import dec_pkg::*;

   logic         f_valid, f_ready;
   dec_task_type f_task;
   logic         q_valid, q_ready;
   logic [TW-1:0] q_data;
   dec_task_type  q_task;

   dec_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .a_pos_x   (req_a_pos_x),
      .a_pos_y   (req_a_pos_y),
      .a_vel_x   (req_a_vel_x),
      .a_vel_y   (req_a_vel_y),
      .a_rad     (req_a_rad),
      .b_pos_x   (req_b_pos_x),
      .b_pos_y   (req_b_pos_y),
      .b_vel_x   (req_b_vel_x),
      .b_vel_y   (req_b_vel_y),
      .b_rad     (req_b_rad),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_task  (f_task)
   );

   dec_fifo #(
      .WIDTH (TW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_task),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign q_task = dec_task_type'(q_data);

   dec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (q_valid),
      .in_ready     (q_ready),
      .in_task      (q_task),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_hit      (rsp_hit),
      .rsp_a_new_vx (rsp_a_new_vx),
      .rsp_a_new_vy (rsp_a_new_vy),
      .rsp_b_new_vx (rsp_b_new_vx),
      .rsp_b_new_vy (rsp_b_new_vy)
   );

endmodule

@@ rtl/dec_front.sv @@
`timescale 1ns / 1ps

module dec_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [dec_pkg::VW-1:0]    a_pos_x,
   input  logic signed [dec_pkg::VW-1:0]    a_pos_y,
   input  logic signed [dec_pkg::VW-1:0]    a_vel_x,
   input  logic signed [dec_pkg::VW-1:0]    a_vel_y,
   input  logic [dec_pkg::RW-1:0]           a_rad,
   input  logic signed [dec_pkg::VW-1:0]    b_pos_x,
   input  logic signed [dec_pkg::VW-1:0]    b_pos_y,
   input  logic signed [dec_pkg::VW-1:0]    b_vel_x,
   input  logic signed [dec_pkg::VW-1:0]    b_vel_y,
   input  logic [dec_pkg::RW-1:0]           b_rad,
   output logic                             out_valid,
   input  logic                             out_ready,
   output dec_pkg::dec_task_type            out_task
);
   import dec_pkg::*;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // stage 1: differences
   logic signed [DW-1:0]  dx1_ff, dy1_ff;
   logic [RSW-1:0]        rs1_ff;
   logic signed [VW-1:0]  avx1_ff, avy1_ff, bvx1_ff, bvy1_ff;
   // stage 2: products
   logic signed [DDW-1:0] dxx2_ff, dyy2_ff;
   logic [RRW-1:0]        rr2_ff;
   logic signed [PW-1:0]  pax2_ff, pay2_ff, pbx2_ff, pby2_ff;
   logic signed [DW-1:0]  dx2_ff, dy2_ff;
   logic signed [VW-1:0]  avx2_ff, avy2_ff, bvx2_ff, bvy2_ff;
   // stage 3: sums
   logic [DDW-1:0]        dd3_ff;
   logic [RRW-1:0]        rr3_ff;
   logic signed [VDW-1:0] vda3_ff, vdb3_ff;
   logic signed [DW-1:0]  dx3_ff, dy3_ff;
   logic signed [VW-1:0]  avx3_ff, avy3_ff, bvx3_ff, bvy3_ff;
   // stage 4: classification
   logic                  hit_in;
   dec_task_type          task_ff;

   assign adv      = !v4_ff || out_ready;
   assign in_ready = adv;
   assign hit_in   = (dd3_ff != '0) && (dd3_ff <= DDW'(rr3_ff)) && (vda3_ff > vdb3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff  <= DW'(b_pos_x) - DW'(a_pos_x);
         dy1_ff  <= DW'(b_pos_y) - DW'(a_pos_y);
         rs1_ff  <= RSW'(a_rad) + RSW'(b_rad);
         avx1_ff <= a_vel_x;
         avy1_ff <= a_vel_y;
         bvx1_ff <= b_vel_x;
         bvy1_ff <= b_vel_y;

         dxx2_ff <= dx1_ff * dx1_ff;
         dyy2_ff <= dy1_ff * dy1_ff;
         rr2_ff  <= rs1_ff * rs1_ff;
         pax2_ff <= avx1_ff * dx1_ff;
         pay2_ff <= avy1_ff * dy1_ff;
         pbx2_ff <= bvx1_ff * dx1_ff;
         pby2_ff <= bvy1_ff * dy1_ff;
         dx2_ff  <= dx1_ff;
         dy2_ff  <= dy1_ff;
         avx2_ff <= avx1_ff;
         avy2_ff <= avy1_ff;
         bvx2_ff <= bvx1_ff;
         bvy2_ff <= bvy1_ff;

         dd3_ff  <= unsigned'(dxx2_ff) + unsigned'(dyy2_ff);
         rr3_ff  <= rr2_ff;
         vda3_ff <= VDW'(pax2_ff) + VDW'(pay2_ff);
         vdb3_ff <= VDW'(pbx2_ff) + VDW'(pby2_ff);
         dx3_ff  <= dx2_ff;
         dy3_ff  <= dy2_ff;
         avx3_ff <= avx2_ff;
         avy3_ff <= avy2_ff;
         bvx3_ff <= bvx2_ff;
         bvy3_ff <= bvy2_ff;

         task_ff.hit <= hit_in;
         task_ff.dx  <= dx3_ff;
         task_ff.dy  <= dy3_ff;
         task_ff.dd  <= dd3_ff;
         task_ff.vda <= vda3_ff;
         task_ff.vdb <= vdb3_ff;
         task_ff.avx <= avx3_ff;
         task_ff.avy <= avy3_ff;
         task_ff.bvx <= bvx3_ff;
         task_ff.bvy <= bvy3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_task  = task_ff;

endmodule

@@ rtl/dec_fifo.sv @@
`timescale 1ns / 1ps
`include "disc_elastic_collision_top_defines.svh"

module dec_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push_w, pop_w;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push_w     = push_valid && push_ready;
   assign pop_w      = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_w)
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop_w)
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (push_w && !pop_w)
            count_ff <= count_ff + 1'b1;
         else if (pop_w && !push_w)
            count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_w)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   `DEC_ASSERT(a_count_range, count_ff <= CW'(DEPTH), "queue count beyond depth")
   `DEC_ASSERT_NEXT(a_count_up, push_w && !pop_w, count_ff == $past(count_ff) + 1'b1, "queue count missed a push")
   `DEC_ASSERT_NEXT(a_count_down, pop_w && !push_w, count_ff == $past(count_ff) - 1'b1, "queue count missed a pop")

endmodule

@@ rtl/dec_back.sv @@
`timescale 1ns / 1ps
`include "disc_elastic_collision_top_defines.svh"

module dec_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  dec_pkg::dec_task_type         in_task,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic signed [dec_pkg::VW-1:0] rsp_a_new_vx,
   output logic signed [dec_pkg::VW-1:0] rsp_a_new_vy,
   output logic signed [dec_pkg::VW-1:0] rsp_b_new_vx,
   output logic signed [dec_pkg::VW-1:0] rsp_b_new_vy
);
   import dec_pkg::*;

   localparam int SW = VW + 3;

   function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] x);
      logic signed [SW-1:0] hi, lo;
      hi = SW'({1'b0, {(VW-1){1'b1}}});
      lo = ~hi;
      if (x > hi)
         return VW'(hi);
      else if (x < lo)
         return VW'(lo);
      return VW'(x);
   endfunction

   logic adv;
   logic rsp_valid_ff;

   // lanes: 0 = A along x, 1 = A along y, 2 = B along x, 3 = B along y
   logic signed [VDW-1:0] vd_w [LANES];
   logic signed [DW-1:0]  dc_w [LANES];
   logic [VDW-1:0]        mv_in [LANES];
   logic [LANES-1:0]      neg_in;

   // stage 1: magnitudes
   logic                  v1_ff;
   logic [VDW-1:0]        mv1_ff [LANES];
   logic [DW-1:0]         mc1_ff [LANES];
   logic [LANES-1:0]      neg1_ff;
   logic                  hit1_ff;
   logic [DDW-1:0]        dd1_ff;
   logic signed [VW-1:0]  avx1_ff, avy1_ff, bvx1_ff, bvy1_ff;

   // stage 2: partial products
   logic                  v2_ff;
   logic [HW+DW-1:0]      lo2_ff [LANES];
   logic [HW+DW-1:0]      hi2_ff [LANES];
   logic [LANES-1:0]      neg2_ff;
   logic                  hit2_ff;
   logic [DDW-1:0]        dd2_ff;
   logic signed [VW-1:0]  avx2_ff, avy2_ff, bvx2_ff, bvy2_ff;
   logic [NW-1:0]         num_in [LANES];

   // divider stages, 0 holds the loaded dividend
   logic                  dv_ff  [QW+1];
   logic [DDW-1:0]        r_ff   [QW+1][LANES];
   logic [QW-1:0]         nq_ff  [QW+1][LANES];
   logic [LANES-1:0]      negd_ff [QW+1];
   logic                  hitd_ff [QW+1];
   logic [DDW-1:0]        ddd_ff [QW+1];
   logic signed [VW-1:0]  avxd_ff [QW+1];
   logic signed [VW-1:0]  avyd_ff [QW+1];
   logic signed [VW-1:0]  bvxd_ff [QW+1];
   logic signed [VW-1:0]  bvyd_ff [QW+1];

   // output
   logic signed [QW:0]    p_w [LANES];
   logic signed [SW-1:0]  nax_w, nay_w, nbx_w, nby_w;
   logic                  hit_out_ff;
   logic signed [VW-1:0]  avx_out_ff, avy_out_ff, bvx_out_ff, bvy_out_ff;

   // remainder below divisor in every lane, at load and at the end
   logic                  rem_load_ok, rem_final_ok;

   assign adv      = !rsp_valid_ff || rsp_ready;
   assign in_ready = adv;

   assign vd_w[0] = in_task.vda;
   assign vd_w[1] = in_task.vda;
   assign vd_w[2] = in_task.vdb;
   assign vd_w[3] = in_task.vdb;
   assign dc_w[0] = in_task.dx;
   assign dc_w[1] = in_task.dy;
   assign dc_w[2] = in_task.dx;
   assign dc_w[3] = in_task.dy;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mv_in[l]  = vd_w[l][VDW-1] ? unsigned'(-vd_w[l]) : unsigned'(vd_w[l]);
         neg_in[l] = vd_w[l][VDW-1] ^ dc_w[l][DW-1];
         num_in[l] = NW'(lo2_ff[l]) + (NW'(hi2_ff[l]) << HW);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         dv_ff[0]  <= 1'b0;
      end else if (adv) begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         dv_ff[0]  <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            mv1_ff[l] <= mv_in[l];
            mc1_ff[l] <= dc_w[l][DW-1] ? unsigned'(-dc_w[l]) : unsigned'(dc_w[l]);
            lo2_ff[l] <= mv1_ff[l][HW-1:0] * mc1_ff[l];
            hi2_ff[l] <= mv1_ff[l][VDW-1:HW] * mc1_ff[l];
            r_ff[0][l]  <= num_in[l][NW-1:QW];
            nq_ff[0][l] <= num_in[l][QW-1:0];
         end
         neg1_ff    <= neg_in;
         hit1_ff    <= in_task.hit;
         dd1_ff     <= in_task.dd;
         avx1_ff    <= in_task.avx;
         avy1_ff    <= in_task.avy;
         bvx1_ff    <= in_task.bvx;
         bvy1_ff    <= in_task.bvy;

         neg2_ff    <= neg1_ff;
         hit2_ff    <= hit1_ff;
         dd2_ff     <= dd1_ff;
         avx2_ff    <= avx1_ff;
         avy2_ff    <= avy1_ff;
         bvx2_ff    <= bvx1_ff;
         bvy2_ff    <= bvy1_ff;

         negd_ff[0] <= neg2_ff;
         hitd_ff[0] <= hit2_ff;
         ddd_ff[0]  <= dd2_ff;
         avxd_ff[0] <= avx2_ff;
         avyd_ff[0] <= avy2_ff;
         bvxd_ff[0] <= bvx2_ff;
         bvyd_ff[0] <= bvy2_ff;
      end
   end

   // one quotient bit per stage; the dividend's low bits shift out as quotient bits shift in
   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [DDW:0]     t_w  [LANES];
      logic [LANES-1:0] ge_w;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            t_w[l]  = {r_ff[k-1][l], nq_ff[k-1][l][QW-1]};
            ge_w[l] = (t_w[l] >= {1'b0, ddd_ff[k-1]});
         end
      end

      always_ff @(posedge clock) begin
         if (reset)
            dv_ff[k] <= 1'b0;
         else if (adv)
            dv_ff[k] <= dv_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int l = 0; l < LANES; l++) begin
               r_ff[k][l]  <= ge_w[l] ? DDW'(t_w[l] - {1'b0, ddd_ff[k-1]}) : DDW'(t_w[l]);
               nq_ff[k][l] <= {nq_ff[k-1][l][QW-2:0], ge_w[l]};
            end
            negd_ff[k] <= negd_ff[k-1];
            hitd_ff[k] <= hitd_ff[k-1];
            ddd_ff[k]  <= ddd_ff[k-1];
            avxd_ff[k] <= avxd_ff[k-1];
            avyd_ff[k] <= avyd_ff[k-1];
            bvxd_ff[k] <= bvxd_ff[k-1];
            bvyd_ff[k] <= bvyd_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++)
         p_w[l] = negd_ff[QW][l] ? -signed'({1'b0, nq_ff[QW][l]})
                                 : signed'({1'b0, nq_ff[QW][l]});
      nax_w = SW'(p_w[2]) + SW'(avxd_ff[QW]) - SW'(p_w[0]);
      nay_w = SW'(p_w[3]) + SW'(avyd_ff[QW]) - SW'(p_w[1]);
      nbx_w = SW'(p_w[0]) + SW'(bvxd_ff[QW]) - SW'(p_w[2]);
      nby_w = SW'(p_w[1]) + SW'(bvyd_ff[QW]) - SW'(p_w[3]);
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (adv)
         rsp_valid_ff <= dv_ff[QW];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_out_ff <= hitd_ff[QW];
         avx_out_ff <= hitd_ff[QW] ? sat_v(nax_w) : avxd_ff[QW];
         avy_out_ff <= hitd_ff[QW] ? sat_v(nay_w) : avyd_ff[QW];
         bvx_out_ff <= hitd_ff[QW] ? sat_v(nbx_w) : bvxd_ff[QW];
         bvy_out_ff <= hitd_ff[QW] ? sat_v(nby_w) : bvyd_ff[QW];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = hit_out_ff;
   assign rsp_a_new_vx = avx_out_ff;
   assign rsp_a_new_vy = avy_out_ff;
   assign rsp_b_new_vx = bvx_out_ff;
   assign rsp_b_new_vy = bvy_out_ff;

   always_comb begin
      rem_load_ok  = 1'b1;
      rem_final_ok = 1'b1;
      for (int l = 0; l < LANES; l++) begin
         if (r_ff[0][l] >= ddd_ff[0])
            rem_load_ok = 1'b0;
         if (r_ff[QW][l] >= ddd_ff[QW])
            rem_final_ok = 1'b0;
      end
   end

   // quotient fits QW bits, so the partial remainder stays below the divisor
   `DEC_ASSERT(a_rem_load, (dv_ff[0] && ddd_ff[0] != '0) |-> rem_load_ok, "dividend overflows quotient")
   `DEC_ASSERT(a_rem_final, (dv_ff[QW] && ddd_ff[QW] != '0) |-> rem_final_ok, "remainder not below divisor")

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
   import dec_pkg::*;

   typedef struct packed {
      logic signed [VW-1:0] apx, apy, avx, avy;
      logic [RW-1:0]        ar;
      logic signed [VW-1:0] bpx, bpy, bvx, bvy;
      logic [RW-1:0]        br;
   } pair_type;

   typedef struct packed {
      logic                 hit;
      logic signed [VW-1:0] anx, any, bnx, bny;
   } bounce_type;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   pair_type cur;
   logic rsp_hit;
   logic signed [VW-1:0] rsp_a_new_vx, rsp_a_new_vy, rsp_b_new_vx, rsp_b_new_vy;

   pair_type   pairs_q[$];
   bounce_type bounce_q[$];
   int errors = 0;
   int send_idle = 0, recv_stall = 0;
   bit req_fire = 0;

   disc_elastic_collision_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_pos_x(cur.apx), .req_a_pos_y(cur.apy),
      .req_a_vel_x(cur.avx), .req_a_vel_y(cur.avy), .req_a_rad(cur.ar),
      .req_b_pos_x(cur.bpx), .req_b_pos_y(cur.bpy),
      .req_b_vel_x(cur.bvx), .req_b_vel_y(cur.bvy), .req_b_rad(cur.br),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_hit(rsp_hit),
      .rsp_a_new_vx(rsp_a_new_vx), .rsp_a_new_vy(rsp_a_new_vy),
      .rsp_b_new_vx(rsp_b_new_vx), .rsp_b_new_vy(rsp_b_new_vy)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // trunc(vd*dc/dd) toward zero, on magnitudes
   function automatic logic signed [79:0] proj(logic signed [79:0] vd,
                                               logic signed [79:0] dc,
                                               logic [79:0] dd);
      logic [159:0] num;
      logic [159:0] q;
      num = (vd < 0 ? -vd : vd) * (dc < 0 ? -dc : dc);
      q = num / dd;
      return ((vd < 0) != (dc < 0)) ? -$signed(q[79:0]) : $signed(q[79:0]);
   endfunction

   function automatic logic signed [VW-1:0] clamp(logic signed [79:0] x);
      if (x > 80'sd8388607) return 24'sh7fffff;
      if (x < -80'sd8388608) return 24'sh800000;
      return x[VW-1:0];
   endfunction

   function automatic bounce_type collide(pair_type p);
      logic signed [79:0] dx, dy, vda, vdb, pax, pay, pbx, pby;
      logic [79:0] dd, rr;
      bounce_type r;
      dx = p.bpx - p.apx;
      dy = p.bpy - p.apy;
      dd = dx * dx + dy * dy;
      rr = (80'(p.ar) + 80'(p.br)) * (80'(p.ar) + 80'(p.br));
      vda = p.avx * dx + p.avy * dy;
      vdb = p.bvx * dx + p.bvy * dy;
      r.hit = (dd != 0) && (dd <= rr) && (vda > vdb);
      r.anx = p.avx; r.any = p.avy; r.bnx = p.bvx; r.bny = p.bvy;
      if (r.hit) begin
         pax = proj(vda, dx, dd); pay = proj(vda, dy, dd);
         pbx = proj(vdb, dx, dd); pby = proj(vdb, dy, dd);
         r.anx = clamp(pbx + (p.avx - pax));
         r.any = clamp(pby + (p.avy - pay));
         r.bnx = clamp(pax + (p.bvx - pbx));
         r.bny = clamp(pay + (p.bvy - pby));
      end
      return r;
   endfunction

   function automatic logic signed [VW-1:0] rnd_v();
      case ($urandom_range(0, 3))
         0: return 24'($urandom());
         1: return $signed(24'($urandom_range(0, 8192))) - 24'sd4096;
         2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
         default: return $signed(24'($urandom_range(0, 65536))) - 24'sd32768;
      endcase
   endfunction

   // mostly near pairs so hits are common
   function automatic pair_type rnd_pair();
      pair_type p;
      p.apx = rnd_v(); p.apy = rnd_v();
      p.avx = rnd_v(); p.avy = rnd_v();
      p.bvx = rnd_v(); p.bvy = rnd_v();
      if ($urandom_range(0, 9) < 7) begin
         p.bpx = p.apx + $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
         p.bpy = p.apy + $signed(24'($urandom_range(0, 16384))) - 24'sd8192;
         p.ar = 23'($urandom_range(0, 8192));
         p.br = 23'($urandom_range(0, 8192));
      end else begin
         p.bpx = rnd_v(); p.bpy = rnd_v();
         p.ar = 23'($urandom()); p.br = 23'($urandom());
      end
      if ($urandom_range(0, 29) == 0) begin
         p.bpx = p.apx; p.bpy = p.apy;
      end
      return p;
   endfunction

   // word accepted at the last rising edge
   always @(posedge clock)
      req_fire <= !reset && req_valid && req_ready;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
         rsp_ready <= 0;
      end else begin
         if (!req_valid || req_fire) begin
            if (pairs_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
               cur <= pairs_q.pop_front();
               req_valid <= 1;
            end else
               req_valid <= 0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // word accepted on req: predict it
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         bounce_q.push_back(collide(cur));
   end

   always @(posedge clock) begin
      bounce_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bounce_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp word");
         end else begin
            e = bounce_q.pop_front();
            if (e != {rsp_hit, rsp_a_new_vx, rsp_a_new_vy, rsp_b_new_vx, rsp_b_new_vy}) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch exp %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                     e.hit, e.anx, e.any, e.bnx, e.bny, rsp_hit,
                     rsp_a_new_vx, rsp_a_new_vy, rsp_b_new_vx, rsp_b_new_vy);
            end
         end
      end
   end

   initial begin
      pair_type p;
      int ph;
      cur = '0;
      req_valid = 0;
      rsp_ready = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      // directed: extremes, coincident centers, head-on, separating, far apart
      p = '0; pairs_q.push_back(p);
      p.ar = 23'h7fffff; p.br = 23'h7fffff; pairs_q.push_back(p);
      p = '0; p.bpx = 24'sd4096; p.ar = 23'd4096; p.avx = 24'sd4096;
      p.bvx = -24'sd4096; pairs_q.push_back(p);
      p.avx = -24'sd4096; p.bvx = 24'sd4096; pairs_q.push_back(p);
      p = '0; p.apx = 24'sh800000; p.apy = 24'sh800000; p.bpx = 24'sh7fffff;
      p.bpy = 24'sh7fffff; p.ar = 23'h7fffff; p.br = 23'h7fffff;
      p.avx = 24'sh7fffff; p.avy = 24'sh7fffff; p.bvx = 24'sh800000;
      p.bvy = 24'sh800000; pairs_q.push_back(p);
      p.avx = 24'sh800000; p.bvx = 24'sh7fffff; pairs_q.push_back(p);
      p = '0; p.bpx = 24'sd1; p.bpy = -24'sd1; p.ar = 23'd2;
      p.avx = 24'sh7fffff; p.avy = 24'sh800000; p.bvx = 24'sh800000;
      p.bvy = 24'sh7fffff; pairs_q.push_back(p);
      p = '0; p.apx = 24'sh7fffff; p.bpx = 24'sh800000; p.ar = 23'd5;
      pairs_q.push_back(p);
      p = '1; pairs_q.push_back(p);
      for (int i = 0; i < 10; i++) pairs_q.push_back(rnd_pair());
      for (ph = 0; ph < 4; ph++) begin
         wait (pairs_q.size() == 0);
         send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 36 : 80) : 0;
         recv_stall = (ph >= 2) ? (ph == 3 ? 36 : 80) : 0;
         for (int i = 0; i < 225; i++) pairs_q.push_back(rnd_pair());
      end
      wait (pairs_q.size() == 0 && !req_valid);
      wait (bounce_q.size() == 0);
      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

   initial begin
      #10ms;
      $display("tb: done, errors");
      $finish;
   end
endmodule
